[rtl/core/srcs_pkg.sv]
`default_nettype none

package srcs_pkg;

  localparam int NODES  = 8;
  localparam int NODE_W = 3;
  localparam int CNT_W  = 8;
  localparam int NCNT_W = 4;
  localparam int LINK_W = 64;
  localparam int REQ_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_TX    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINK_MATRIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'd1;

  localparam logic [NCNT_W-1:0] NCNT_RESET = 4'd8;

  typedef struct packed {
    logic load;
  } ctl_cmd_t;

endpackage

`default_nettype wire

[rtl/core/shared_radio_carrier_sense.sv]
// Carrier sense on a shared radio channel of up to eight nodes.
// Input channel: in_valid/in_stall with in_req_type (transmit, stop,
// query), in_node and in_tx_bit. A transfer happens when in_valid is
// high and in_stall is low.
// Output channel: out_valid/out_stall with out_hears and out_carrier_mask;
// every input transfer yields exactly one output transfer.
// The result is registered: it is on the output register in the cycle after
// the input transfer. One item per cycle while out_stall is low; all node
// counters update in parallel from one row of the link matrix.
// Configuration: cfg_we/cfg_index/cfg_wdata; index 0 is the link matrix
// (bit sender*8+receiver), index 1 the node count. Write only when idle.
// Reset: counters and transmit flags clear, matrix goes to all ones,
// node count to 8, output register empty.
// Stall: while the output register holds a result and out_stall is high,
// in_stall is high and the result holds.
`default_nettype none

module shared_radio_carrier_sense (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [srcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srcs_pkg::LINK_W-1:0]     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [srcs_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [srcs_pkg::NODE_W-1:0]     in_node,
  input  wire logic                            in_tx_bit,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_hears,
  output logic [7:0]                           out_carrier_mask
);
  import srcs_pkg::*;

  ctl_cmd_t cmd;

  srcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  srcs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_node          (in_node),
    .in_tx_bit        (in_tx_bit),
    .out_hears        (out_hears),
    .out_carrier_mask (out_carrier_mask)
  );

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("input transfer not followed by a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result is blocked");

  a_hears_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hears) |-> (out_carrier_mask != 8'd0))
    else $error("hears set with empty carrier mask");

  a_idle_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !in_valid) |=> !out_valid)
    else $error("result repeated after transfer");
`endif

endmodule

`default_nettype wire

[rtl/core/srcs_ctrl.sv]
`default_nettype none

module srcs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output srcs_pkg::ctl_cmd_t     cmd
);
  import srcs_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_stall  = (state_r == ST_FULL) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_FULL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (accept) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (!accept && !out_stall) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load = accept;

endmodule

`default_nettype wire

[rtl/core/srcs_dp.sv]
`default_nettype none

module srcs_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire srcs_pkg::ctl_cmd_t              cmd,
  input  wire logic                            cfg_we,
  input  wire logic [srcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srcs_pkg::LINK_W-1:0]     cfg_wdata,
  input  wire logic [srcs_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [srcs_pkg::NODE_W-1:0]     in_node,
  input  wire logic                            in_tx_bit,
  output logic                                 out_hears,
  output logic [7:0]                           out_carrier_mask
);
  import srcs_pkg::*;

  logic [CNT_W-1:0]  cnt_r   [NODES];
  logic [CNT_W-1:0]  cnt_nxt [NODES];
  logic [NODES-1:0]  flag_r;
  logic [NODES-1:0]  flag_nxt;
  logic [LINK_W-1:0] link_r;
  logic [NCNT_W-1:0] ncnt_r;
  logic              hears_r;
  logic              hears_nxt;
  logic [7:0]        mask_r;
  logic [7:0]        mask_nxt;
  logic [NCNT_W-1:0] live;
  logic              who_ok;
  logic              do_inc;
  logic              do_dec;
  logic              lnk;

  assign live   = (ncnt_r > NCNT_W'(NODES)) ? NCNT_W'(NODES) : ncnt_r;
  assign who_ok = ({1'b0, in_node} < NCNT_W'(NODES));
  assign do_inc = who_ok && (in_req_type == REQ_TX) && in_tx_bit;
  assign do_dec = who_ok && (in_req_type == REQ_STOP) && flag_r[in_node];

  // per-node counter lanes
  always_comb begin
    flag_nxt = flag_r;
    if (who_ok && (in_req_type == REQ_TX)) flag_nxt[in_node] = in_tx_bit;
    if (do_dec) flag_nxt[in_node] = 1'b0;
    mask_nxt = '0;
    for (int i = 0; i < NODES; i++) begin
      lnk = link_r[{in_node, NODE_W'(i)}] && (NCNT_W'(i) < live);
      cnt_nxt[i] = cnt_r[i];
      if (do_inc && lnk && (cnt_r[i] != {CNT_W{1'b1}}))
        cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
      else if (do_dec && lnk && (cnt_r[i] != '0))
        cnt_nxt[i] = cnt_r[i] - CNT_W'(1);
      mask_nxt[i] = (cnt_nxt[i] != '0);
    end
    hears_nxt = who_ok && mask_nxt[in_node];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) cnt_r[i] <= '0;
      flag_r <= '0;
    end else if (cmd.load) begin
      for (int i = 0; i < NODES; i++) cnt_r[i] <= cnt_nxt[i];
      flag_r <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= {LINK_W{1'b1}};
      ncnt_r <= NCNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINK_MATRIX: link_r <= cfg_wdata;
        CFG_NODE_COUNT:  ncnt_r <= cfg_wdata[NCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hears_r <= hears_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign out_hears        = hears_r;
  assign out_carrier_mask = mask_r;

endmodule

`default_nettype wire

[verif/tb_shared_radio_carrier_sense.sv]
`default_nettype none

module tb_shared_radio_carrier_sense;
  timeunit 1ns;
  timeprecision 1ps;

  import srcs_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic       hears;
    logic [7:0] mask;
  } sense_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [LINK_W-1:0]    data;
    logic [REQ_W-1:0]     req;
    logic [NODE_W-1:0]    who;
    logic                 b;
    bit                   pinned;
    sense_t               want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LINK_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type;
  logic [NODE_W-1:0]    in_node;
  logic                 in_tx_bit;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hears;
  logic [7:0]           out_carrier_mask;

  shared_radio_carrier_sense u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_node          (in_node),
    .in_tx_bit        (in_tx_bit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hears        (out_hears),
    .out_carrier_mask (out_carrier_mask)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // channel model
  logic [CNT_W-1:0]  heard_cnt [NODES];
  logic              tx_flag   [NODES];
  logic [LINK_W-1:0] link_bits;
  logic [NCNT_W-1:0] live_cfg;

  sense_t sense_q [$];
  int     miss_cnt = 0;
  bit     rush = 1'b0;

  function automatic sense_t carrier_step(input logic [REQ_W-1:0] req,
                                          input logic [NODE_W-1:0] who,
                                          input logic b);
    sense_t r;
    int     lim;
    int     i;
    lim = (live_cfg > NODES) ? NODES : int'(live_cfg);
    if (req == REQ_TX) begin
      tx_flag[who] = b;
      if (b) begin
        for (i = 0; i < lim; i++)
          if (link_bits[int'(who) * 8 + i] && heard_cnt[i] != 8'hFF)
            heard_cnt[i] = heard_cnt[i] + 8'd1;
      end
    end else if (req == REQ_STOP && tx_flag[who]) begin
      tx_flag[who] = 1'b0;
      for (i = 0; i < lim; i++)
        if (link_bits[int'(who) * 8 + i] && heard_cnt[i] != 8'h00)
          heard_cnt[i] = heard_cnt[i] - 8'd1;
    end
    r.hears = (heard_cnt[who] != 8'h00);
    for (i = 0; i < NODES; i++)
      r.mask[i] = (heard_cnt[i] != 8'h00);
    return r;
  endfunction

  task automatic report_miss(input string msg);
    if (miss_cnt < 40)
      $display("MISMATCH @%0t: %s", $realtime, msg);
    miss_cnt++;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] who,
                      input logic b, input bit pinned = 1'b0,
                      input sense_t want = '0);
    int     gap;
    sense_t got;
    gap = rush ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_node     <= who;
    in_tx_bit   <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = carrier_step(req, who, b);
    sense_q.push_back(pinned ? want : got);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sense_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LINK_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LINK_MATRIX)
      link_bits = data;
    else
      live_cfg = data[NCNT_W-1:0];
  endtask

  function automatic step_t item_row(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] who,
                                     input logic b, input bit pinned, input logic hears,
                                     input logic [7:0] mask);
    step_t s;
    s = '{default: '0};
    s.req    = req;
    s.who    = who;
    s.b      = b;
    s.pinned = pinned;
    s.want   = '{hears, mask};
    return s;
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [LINK_W-1:0] data);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  always @(posedge clk) begin
    sense_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (sense_q.size() == 0) begin
        report_miss($sformatf("unexpected transfer hears=%0b mask=%02h",
                              out_hears, out_carrier_mask));
      end else begin
        want = sense_q.pop_front();
        if (out_hears !== want.hears)
          report_miss($sformatf("hears %0b, want %0b", out_hears, want.hears));
        if (out_carrier_mask !== want.mask)
          report_miss($sformatf("carrier_mask %02h, want %02h",
                                out_carrier_mask, want.mask));
      end
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = rush ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1 && out_stall == 1'b0));
    end
  end

  initial begin
    #2_000_000;
    $display("tb_shared_radio_carrier_sense NOT OK");
    $finish;
  end

  initial begin
    step_t            plan [$];
    int               ph;
    int               k;
    int               top;
    int               rounds;
    int               pick;
    logic [NODE_W-1:0] who;
    logic             b;
    logic [LINK_W-1:0] word;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_req_type = '0;
    in_node     = '0;
    in_tx_bit   = 1'b0;
    link_bits   = '1;
    live_cfg    = NCNT_RESET;
    for (k = 0; k < NODES; k++) begin
      heard_cnt[k] = '0;
      tx_flag[k]   = 1'b0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan.push_back(item_row(REQ_QUERY,  3'd0, 1'b0, 1, 1'b0, 8'h00));
    plan.push_back(item_row(REQ_UNUSED, 3'd7, 1'b1, 1, 1'b0, 8'h00));
    plan.push_back(item_row(REQ_STOP,   3'd3, 1'b0, 1, 1'b0, 8'h00));
    plan.push_back(item_row(REQ_TX,     3'd5, 1'b0, 1, 1'b0, 8'h00));
    plan.push_back(item_row(REQ_TX,     3'd0, 1'b1, 1, 1'b1, 8'hFF));
    plan.push_back(item_row(REQ_TX,     3'd0, 1'b1, 1, 1'b1, 8'hFF));
    plan.push_back(item_row(REQ_STOP,   3'd0, 1'b1, 1, 1'b1, 8'hFF));
    plan.push_back(item_row(REQ_STOP,   3'd0, 1'b0, 1, 1'b1, 8'hFF));
    // zero node count: flag set, counters untouched
    plan.push_back(reg_row(CFG_NODE_COUNT, 64'd0));
    plan.push_back(item_row(REQ_TX,     3'd6, 1'b1, 1, 1'b1, 8'hFF));
    plan.push_back(reg_row(CFG_NODE_COUNT, 64'd8));
    plan.push_back(item_row(REQ_STOP,   3'd6, 1'b0, 1, 1'b0, 8'h00));
    // decrement floor at zero
    plan.push_back(reg_row(CFG_NODE_COUNT, 64'd0));
    plan.push_back(item_row(REQ_TX,     3'd2, 1'b1, 1, 1'b0, 8'h00));
    plan.push_back(reg_row(CFG_NODE_COUNT, 64'd8));
    plan.push_back(item_row(REQ_STOP,   3'd2, 1'b1, 1, 1'b0, 8'h00));
    plan.push_back(reg_row(CFG_LINK_MATRIX, 64'd0));
    plan.push_back(item_row(REQ_TX,     3'd1, 1'b1, 1, 1'b0, 8'h00));
    plan.push_back(item_row(REQ_STOP,   3'd1, 1'b0, 1, 1'b0, 8'h00));
    // node 5 hears node 3 only
    plan.push_back(reg_row(CFG_LINK_MATRIX, 64'd1 << 29));
    plan.push_back(item_row(REQ_TX,     3'd3, 1'b1, 1, 1'b0, 8'h20));
    plan.push_back(item_row(REQ_QUERY,  3'd5, 1'b1, 1, 1'b1, 8'h20));
    plan.push_back(reg_row(CFG_NODE_COUNT, '1));
    plan.push_back(item_row(REQ_TX,     3'd3, 1'b1, 0, 1'b0, 8'h00));
    plan.push_back(reg_row(CFG_NODE_COUNT, 64'hA5A5_A5A5_A5A5_A5A5));
    plan.push_back(item_row(REQ_STOP,   3'd3, 1'b1, 0, 1'b0, 8'h00));
    plan.push_back(reg_row(CFG_LINK_MATRIX, 64'd1 << 63));
    plan.push_back(reg_row(CFG_NODE_COUNT, 64'd8));
    plan.push_back(item_row(REQ_TX,     3'd7, 1'b1, 1, 1'b1, 8'hA0));
    plan.push_back(reg_row(CFG_LINK_MATRIX, '1));
    plan.push_back(item_row(REQ_STOP,   3'd7, 1'b0, 1, 1'b0, 8'h20));
    plan.push_back(item_row(REQ_UNUSED, 3'd5, 1'b0, 1, 1'b1, 8'h20));

    foreach (plan[j]) begin
      if (plan[j].is_cfg)
        write_reg(plan[j].idx, plan[j].data);
      else
        send(plan[j].req, plan[j].who, plan[j].b, plan[j].pinned, plan[j].want);
    end

    for (ph = 0; ph < 11; ph++) begin
      rush = ($urandom_range(0, 3) == 0);
      case (ph % 5)
        0: word = '1;
        1: word = '0;
        2: word = {$urandom, $urandom};
        3: word = {$urandom, $urandom} & {$urandom, $urandom};
        default: word = ~({$urandom, $urandom} & {$urandom, $urandom});
      endcase
      write_reg(CFG_LINK_MATRIX, word);
      word = {$urandom, $urandom};
      case (ph)
        1: word[3:0] = 4'd0;
        2: word[3:0] = 4'd15;
        3: word[3:0] = 4'd1;
        4: word[3:0] = 4'd8;
        default: word[3:0] = ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
      endcase
      write_reg(CFG_NODE_COUNT, word);

      repeat (70) begin
        who  = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        b    = 1'($urandom_range(0, 1));
        if (tx_flag[who]) begin
          if (pick < 60)      send(REQ_STOP, who, b);
          else if (pick < 70) send(REQ_TX, who, 1'b1);
          else if (pick < 75) send(REQ_TX, who, 1'b0);
          else if (pick < 93) send(REQ_QUERY, who, b);
          else                send(REQ_UNUSED, who, b);
        end else begin
          if (pick < 55)      send(REQ_TX, who, 1'b1);
          else if (pick < 65) send(REQ_TX, who, 1'b0);
          else if (pick < 75) send(REQ_STOP, who, b);
          else if (pick < 93) send(REQ_QUERY, who, b);
          else                send(REQ_UNUSED, who, b);
        end
      end

      // bleed counters down: arm every flag without counting, then stop all
      top = 0;
      for (k = 0; k < NODES; k++)
        if (int'(heard_cnt[k]) > top) top = int'(heard_cnt[k]);
      rounds = (top + 7) / 8;
      if (rounds > 6) rounds = 6;
      repeat (rounds) begin
        write_reg(CFG_NODE_COUNT, 64'd0);
        for (k = 0; k < NODES; k++) send(REQ_TX, 3'(k), 1'b1);
        write_reg(CFG_LINK_MATRIX, '1);
        write_reg(CFG_NODE_COUNT, 64'd8);
        for (k = 0; k < NODES; k++) send(REQ_STOP, 3'(k), 1'($urandom_range(0, 1)));
      end
    end

    // drive counters into the 255 ceiling
    rush = 1'b0;
    write_reg(CFG_LINK_MATRIX, '1);
    write_reg(CFG_NODE_COUNT, 64'd8);
    repeat (300) begin
      who = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 95)
        send(REQ_TX, who, 1'b1);
      else
        send(REQ_QUERY, who, 1'($urandom_range(0, 1)));
    end
    for (k = 0; k < NODES; k++) send(REQ_STOP, 3'(k), 1'b0);
    for (k = 0; k < NODES; k++) send(REQ_TX, 3'(k), 1'b1);
    for (k = 0; k < NODES; k++) send(REQ_QUERY, 3'(k), 1'b1);

    settle();
    repeat (8) @(negedge clk);
    if (miss_cnt == 0)
      $display("tb_shared_radio_carrier_sense OK");
    else
      $display("tb_shared_radio_carrier_sense NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/srcs_pkg.sv
rtl/core/srcs_ctrl.sv
rtl/core/srcs_dp.sv
rtl/core/shared_radio_carrier_sense.sv
verif/tb_shared_radio_carrier_sense.sv
